FILE: rtl/direct_mapped_kv_cache_assert.svh
// Assertion macros for the direct-mapped key-value cache.
`ifndef DIRECT_MAPPED_KV_CACHE_ASSERT_SVH
`define DIRECT_MAPPED_KV_CACHE_ASSERT_SVH

`ifndef SYNTHESIS
`define DMKV_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("dmkv assertion failed");
`define DMKV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dmkv assertion failed");
`else
`define DMKV_ASSERT(lbl, clk, rst_n, prop)
`define DMKV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/dmkv_pkg.sv
// Shared types and constants of the direct-mapped key-value cache.
package dmkv_pkg;

    localparam int SLOTS           = 1024;
    localparam int MAX_VALUE_BYTES = 256;
    localparam int WORDS_PER_SLOT  = (MAX_VALUE_BYTES + 7) / 8;

    localparam int KEY_W   = 64;
    localparam int DATA_W  = 64;
    localparam int LEN_W   = 9;
    localparam int WIDX_W  = 5;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int WSEL_W  = $clog2(WORDS_PER_SLOT);
    localparam int VADDR_W = SLOT_W + WSEL_W;
    localparam int WCNT_W  = LEN_W - 2;

    localparam logic CMD_PUT = 1'b0;
    localparam logic CMD_GET = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_STREAM
    } state_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [LEN_W-1:0] length;
    } meta_t;

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        meta_t             wdata;
        logic              re;
        logic [SLOT_W-1:0] raddr;
    } meta_req_t;

    typedef struct packed {
        logic               we;
        logic [VADDR_W-1:0] waddr;
        logic [DATA_W-1:0]  wdata;
        logic               re;
        logic [VADDR_W-1:0] raddr;
    } val_req_t;

    // key * 31, kept to the slot bits (SLOTS is a power of two)
    function automatic logic [SLOT_W-1:0] slot_of(input logic [KEY_W-1:0] key);
        logic [SLOT_W+4:0] k;
        k = {5'b0, key[SLOT_W-1:0]};
        return SLOT_W'((k << 5) - k);
    endfunction

endpackage

FILE: rtl/dmkv_ram.sv
// Simple dual-port synchronous RAM with registered read data.
module dmkv_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/dmkv_ctrl.sv
// Control sequencer: clearing pass, put writes, get lookup and value streaming.
module dmkv_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            command,
    input  logic [dmkv_pkg::KEY_W-1:0]      key,
    input  logic [dmkv_pkg::LEN_W-1:0]      length,
    input  logic [dmkv_pkg::WIDX_W-1:0]     word_index,
    input  logic [dmkv_pkg::DATA_W-1:0]     data_word,
    input  logic                            final_word,
    input  logic [dmkv_pkg::LEN_W-1:0]      capacity,
    input  dmkv_pkg::meta_t                 meta_rdata,
    input  logic [dmkv_pkg::DATA_W-1:0]     val_rdata,
    output logic                            busy,
    output logic                            strobe,
    output logic                            status,
    output logic [dmkv_pkg::DATA_W-1:0]     value_word,
    output logic [dmkv_pkg::WIDX_W-1:0]     out_index,
    output logic [dmkv_pkg::LEN_W-1:0]      stored_length,
    output logic                            last,
    output dmkv_pkg::meta_req_t             meta_req,
    output dmkv_pkg::val_req_t              val_req
);

    dmkv_pkg::state_t                   state_reg, state_next;
    logic [dmkv_pkg::SLOT_W-1:0]        clr_idx_reg, clr_idx_next;
    logic [dmkv_pkg::SLOT_W-1:0]        slot_reg, slot_next;
    logic [dmkv_pkg::KEY_W-1:0]         key_reg, key_next;
    logic [dmkv_pkg::LEN_W-1:0]         cap_reg, cap_next;
    logic [dmkv_pkg::WSEL_W-1:0]        emit_idx_reg, emit_idx_next;

    logic                               strobe_reg, strobe_next;
    logic                               status_reg, status_next;
    logic [dmkv_pkg::DATA_W-1:0]        value_word_reg, value_word_next;
    logic [dmkv_pkg::WIDX_W-1:0]        out_index_reg, out_index_next;
    logic [dmkv_pkg::LEN_W-1:0]         stored_length_reg, stored_length_next;
    logic                               last_reg, last_next;

    logic                               accept;
    logic                               put_ok;
    logic                               put_in_range;
    logic [dmkv_pkg::SLOT_W-1:0]        slot_in;
    logic                               hit;
    logic [dmkv_pkg::WCNT_W-1:0]        word_count;
    logic                               last_word;
    logic [2:0]                         tail;
    logic [dmkv_pkg::DATA_W-1:0]        masked_word;

    assign busy    = (state_reg != dmkv_pkg::ST_IDLE);
    assign accept  = start && (state_reg == dmkv_pkg::ST_IDLE);
    assign slot_in = dmkv_pkg::slot_of(key);
    assign put_ok  = ({1'b0, length} <= (dmkv_pkg::LEN_W + 1)'(dmkv_pkg::MAX_VALUE_BYTES));
    assign put_in_range = (32'(word_index) < dmkv_pkg::WORDS_PER_SLOT);

    assign hit = (meta_rdata.key == key_reg) && (meta_rdata.length != '0)
              && (cap_reg >= meta_rdata.length);

    // words of the stored value, rounded up
    assign word_count = dmkv_pkg::WCNT_W'(((dmkv_pkg::LEN_W + 1)'(meta_rdata.length)
                                           + (dmkv_pkg::LEN_W + 1)'(7)) >> 3);
    assign last_word  = ((dmkv_pkg::WCNT_W'(emit_idx_reg) + dmkv_pkg::WCNT_W'(1)) == word_count);
    assign tail       = meta_rdata.length[2:0];

    // zero the bytes past the stored length on a partial final word
    always_comb
    begin
        masked_word = val_rdata;
        for (int b = 0; b < 8; b++)
        begin
            if (last_word && (tail != 3'd0) && (3'(b) >= tail))
            begin
                masked_word[b*8 +: 8] = 8'h00;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dmkv_pkg::ST_CLEAR:
            begin
                if (clr_idx_reg == dmkv_pkg::SLOT_W'(dmkv_pkg::SLOTS - 1))
                begin
                    state_next = dmkv_pkg::ST_IDLE;
                end
            end
            dmkv_pkg::ST_IDLE:
            begin
                if (accept && (command == dmkv_pkg::CMD_GET))
                begin
                    state_next = dmkv_pkg::ST_LOOKUP;
                end
            end
            dmkv_pkg::ST_LOOKUP:
            begin
                if (hit && !last_word)
                begin
                    state_next = dmkv_pkg::ST_STREAM;
                end
                else
                begin
                    state_next = dmkv_pkg::ST_IDLE;
                end
            end
            dmkv_pkg::ST_STREAM:
            begin
                if (last_word)
                begin
                    state_next = dmkv_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dmkv_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        clr_idx_next       = clr_idx_reg;
        slot_next          = slot_reg;
        key_next           = key_reg;
        cap_next           = cap_reg;
        emit_idx_next      = emit_idx_reg;
        strobe_next        = 1'b0;
        status_next        = dmkv_pkg::STATUS_OK;
        value_word_next    = '0;
        out_index_next     = '0;
        stored_length_next = '0;
        last_next          = 1'b1;
        meta_req           = '0;
        val_req            = '0;

        unique case (state_reg)
            dmkv_pkg::ST_CLEAR:
            begin
                meta_req.we    = 1'b1;
                meta_req.waddr = clr_idx_reg;
                clr_idx_next   = clr_idx_reg + dmkv_pkg::SLOT_W'(1);
            end
            dmkv_pkg::ST_IDLE:
            begin
                if (accept && (command == dmkv_pkg::CMD_PUT))
                begin
                    val_req.we    = put_ok && put_in_range;
                    val_req.waddr = {slot_in, dmkv_pkg::WSEL_W'(word_index)};
                    val_req.wdata = data_word;
                    if (final_word)
                    begin
                        strobe_next          = 1'b1;
                        status_next          = put_ok ? dmkv_pkg::STATUS_OK
                                                      : dmkv_pkg::STATUS_FAIL;
                        meta_req.we          = put_ok;
                        meta_req.waddr       = slot_in;
                        meta_req.wdata.key   = key;
                        meta_req.wdata.length = length;
                    end
                end
                else if (accept)
                begin
                    // fetch the slot header and the first value word together
                    meta_req.re   = 1'b1;
                    meta_req.raddr = slot_in;
                    val_req.re    = 1'b1;
                    val_req.raddr = {slot_in, dmkv_pkg::WSEL_W'(0)};
                    slot_next     = slot_in;
                    key_next      = key;
                    cap_next      = capacity;
                    emit_idx_next = '0;
                end
            end
            dmkv_pkg::ST_LOOKUP,
            dmkv_pkg::ST_STREAM:
            begin
                if (hit || (state_reg == dmkv_pkg::ST_STREAM))
                begin
                    strobe_next        = 1'b1;
                    value_word_next    = masked_word;
                    out_index_next     = dmkv_pkg::WIDX_W'(emit_idx_reg);
                    stored_length_next = meta_rdata.length;
                    last_next          = last_word;
                    val_req.re         = 1'b1;
                    val_req.raddr      = {slot_reg, emit_idx_reg + dmkv_pkg::WSEL_W'(1)};
                    emit_idx_next      = emit_idx_reg + dmkv_pkg::WSEL_W'(1);
                end
                else
                begin
                    strobe_next = 1'b1;
                    status_next = dmkv_pkg::STATUS_FAIL;
                end
            end
            default:
            begin
                strobe_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= dmkv_pkg::ST_CLEAR;
            clr_idx_reg <= '0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            strobe_reg  <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg          <= slot_next;
        key_reg           <= key_next;
        cap_reg           <= cap_next;
        emit_idx_reg      <= emit_idx_next;
        status_reg        <= status_next;
        value_word_reg    <= value_word_next;
        out_index_reg     <= out_index_next;
        stored_length_reg <= stored_length_next;
        last_reg          <= last_next;
    end

    assign strobe        = strobe_reg;
    assign status        = status_reg;
    assign value_word    = value_word_reg;
    assign out_index     = out_index_reg;
    assign stored_length = stored_length_reg;
    assign last          = last_reg;

endmodule

FILE: rtl/direct_mapped_kv_cache.sv
// Top level of the direct-mapped key-value cache.
// Commands enter on start while busy is low; all command fields are sampled then.
// A put moves one value word per item and never raises busy: an item can
// follow in every cycle. The final item of a put yields one status result on
// the cycle after it is taken (failure when the length exceeds the maximum).
// A get raises busy, reads the slot header and first value word from the
// memories, then gives its results one per cycle: a single failure on a
// miss, or ceil(length/8) value words with last on the final one.
// A get thus keeps busy high until its final result appears.
// Results appear for one cycle with strobe high; the receiver cannot stall.
// After reset the block sweeps the header memory, one slot per cycle, with
// busy high, which marks every slot empty.
`include "direct_mapped_kv_cache_assert.svh"

module direct_mapped_kv_cache (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            command,
    input  logic [dmkv_pkg::KEY_W-1:0]      key,
    input  logic [dmkv_pkg::LEN_W-1:0]      length,
    input  logic [dmkv_pkg::WIDX_W-1:0]     word_index,
    input  logic [dmkv_pkg::DATA_W-1:0]     data_word,
    input  logic                            final_word,
    input  logic [dmkv_pkg::LEN_W-1:0]      capacity,
    output logic                            strobe,
    output logic                            status,
    output logic [dmkv_pkg::DATA_W-1:0]     value_word,
    output logic [dmkv_pkg::WIDX_W-1:0]     out_index,
    output logic [dmkv_pkg::LEN_W-1:0]      stored_length,
    output logic                            last
);

    dmkv_pkg::meta_req_t             meta_req;
    dmkv_pkg::val_req_t              val_req;
    dmkv_pkg::meta_t                 meta_rdata;
    logic [dmkv_pkg::DATA_W-1:0]     val_rdata;

    dmkv_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .command       (command),
        .key           (key),
        .length        (length),
        .word_index    (word_index),
        .data_word     (data_word),
        .final_word    (final_word),
        .capacity      (capacity),
        .meta_rdata    (meta_rdata),
        .val_rdata     (val_rdata),
        .busy          (busy),
        .strobe        (strobe),
        .status        (status),
        .value_word    (value_word),
        .out_index     (out_index),
        .stored_length (stored_length),
        .last          (last),
        .meta_req      (meta_req),
        .val_req       (val_req)
    );

    dmkv_ram #(
        .WIDTH ($bits(dmkv_pkg::meta_t)),
        .DEPTH (dmkv_pkg::SLOTS)
    ) u_meta_ram (
        .clk   (clk),
        .we    (meta_req.we),
        .waddr (meta_req.waddr),
        .wdata (meta_req.wdata),
        .re    (meta_req.re),
        .raddr (meta_req.raddr),
        .rdata (meta_rdata)
    );

    dmkv_ram #(
        .WIDTH (dmkv_pkg::DATA_W),
        .DEPTH (dmkv_pkg::SLOTS * dmkv_pkg::WORDS_PER_SLOT)
    ) u_value_ram (
        .clk   (clk),
        .we    (val_req.we),
        .waddr (val_req.waddr),
        .wdata (val_req.wdata),
        .re    (val_req.re),
        .raddr (val_req.raddr),
        .rdata (val_rdata)
    );

    `DMKV_ASSERT(a_stream_holds_busy, clk, rst_n, (strobe && !last) |-> busy)
    `DMKV_ASSERT_NEXT(a_get_sets_busy, clk, rst_n, start && !busy && (command == dmkv_pkg::CMD_GET), busy)
    `DMKV_ASSERT_NEXT(a_index_advances, clk, rst_n, strobe && !last, strobe && (out_index == $past(out_index) + 5'd1))
    `DMKV_ASSERT(a_fail_is_single, clk, rst_n, (strobe && (status == dmkv_pkg::STATUS_FAIL)) |-> (last && (value_word == '0)))

endmodule

FILE: tb/kv_cache_checker.sv
// Checker for the direct-mapped key-value cache: mirrors the cache contents and checks each result.
module kv_cache_checker
    import dmkv_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic              command,
    input  logic [KEY_W-1:0]  key,
    input  logic [LEN_W-1:0]  length,
    input  logic [WIDX_W-1:0] word_index,
    input  logic [DATA_W-1:0] data_word,
    input  logic              final_word,
    input  logic [LEN_W-1:0]  capacity,
    input  logic              strobe,
    input  logic              status,
    input  logic [DATA_W-1:0] value_word,
    input  logic [WIDX_W-1:0] out_index,
    input  logic [LEN_W-1:0]  stored_length,
    input  logic              last,
    output int                fail_count,
    output int                outstanding,
    output int                results_checked,
    output int                get_hits
);

    typedef struct packed {
        logic              status;
        logic [DATA_W-1:0] word;
        logic [WIDX_W-1:0] index;
        logic [LEN_W-1:0]  length;
        logic              last;
    } reply_t;

    bit [KEY_W-1:0]  key_mirror  [SLOTS];
    bit [LEN_W-1:0]  len_mirror  [SLOTS];
    bit [DATA_W-1:0] word_mirror [SLOTS*WORDS_PER_SLOT];

    reply_t expected_replies [$];
    int     mismatches = 0;
    int     checked    = 0;
    int     hits       = 0;

    function automatic reply_t single_reply(input logic st);
        reply_t r;
        r        = '0;
        r.status = st;
        r.last   = 1'b1;
        return r;
    endfunction

    task automatic predict_item(
        input logic              cmd,
        input logic [KEY_W-1:0]  k,
        input logic [LEN_W-1:0]  len,
        input logic [WIDX_W-1:0] widx,
        input logic [DATA_W-1:0] data,
        input logic              fin,
        input logic [LEN_W-1:0]  cap
    );
        int     s;
        int     slen;
        int     nw;
        int     rem;
        int     i;
        logic   ok;
        reply_t r;
        s = int'((k * 64'd31) % SLOTS);
        if (cmd == CMD_PUT) begin
            ok = (len <= MAX_VALUE_BYTES);
            if (ok && widx < WORDS_PER_SLOT)
                word_mirror[s*WORDS_PER_SLOT + widx] = data;
            if (fin) begin
                if (ok) begin
                    key_mirror[s] = k;
                    len_mirror[s] = len;
                end
                expected_replies.push_back(single_reply(ok ? STATUS_OK : STATUS_FAIL));
            end
        end
        else begin
            slen = len_mirror[s];
            if (key_mirror[s] != k || slen == 0 || cap < slen) begin
                expected_replies.push_back(single_reply(STATUS_FAIL));
            end
            else begin
                hits++;
                nw = (slen + 7) / 8;
                if (nw > WORDS_PER_SLOT)
                    nw = WORDS_PER_SLOT;
                for (i = 0; i < nw; i++) begin
                    r.status = STATUS_OK;
                    r.word   = word_mirror[s*WORDS_PER_SLOT + i];
                    rem      = slen - i * 8;
                    // zero the bytes past the stored length
                    if (rem < 8)
                        r.word &= (64'd1 << (rem * 8)) - 64'd1;
                    r.index  = WIDX_W'(i);
                    r.length = LEN_W'(slen);
                    r.last   = (i + 1 == nw);
                    expected_replies.push_back(r);
                end
            end
        end
    endtask

    always @(posedge clk) begin : watch
        reply_t want;
        if (rst_n) begin
            // check the result first: it always belongs to an earlier item
            if (strobe === 1'b1) begin
                if (expected_replies.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: result with nothing expected: status=%0d word=%h idx=%0d len=%0d last=%0d",
                                 status, value_word, out_index, stored_length, last);
                end
                else begin
                    want = expected_replies.pop_front();
                    checked++;
                    if (status !== want.status || value_word !== want.word ||
                        out_index !== want.index || stored_length !== want.length ||
                        last !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("ERROR: result %0d expected status=%0d word=%h idx=%0d len=%0d last=%0d",
                                     checked, want.status, want.word, want.index, want.length,
                                     want.last);
                            $display("       got      status=%0d word=%h idx=%0d len=%0d last=%0d",
                                     status, value_word, out_index, stored_length, last);
                        end
                    end
                end
            end
            if (start === 1'b1 && busy === 1'b0)
                predict_item(command, key, length, word_index, data_word, final_word, capacity);
        end
        fail_count      <= mismatches;
        outstanding     <= expected_replies.size();
        results_checked <= checked;
        get_hits        <= hits;
    end

endmodule

FILE: tb/tb_direct_mapped_kv_cache.sv
// Testbench top for the direct-mapped key-value cache: clock, reset, stimulus and verdict.
module tb_direct_mapped_kv_cache;
    import dmkv_pkg::*;

    localparam int ITEM_TARGET    = 360;    // short directed part plus random items
    localparam int WATCHDOG_LIMIT = 5000;   // well above the clear pass after reset
    localparam int DRAIN_CYCLES   = 40;
    localparam int POOL_SIZE      = 12;

    typedef enum {PUT_FULL, PUT_SHUFFLED, PUT_PARTIAL} put_shape_e;

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              start      = 1'b0;
    logic              command    = CMD_PUT;
    logic [KEY_W-1:0]  key        = '0;
    logic [LEN_W-1:0]  length     = '0;
    logic [WIDX_W-1:0] word_index = '0;
    logic [DATA_W-1:0] data_word  = '0;
    logic              final_word = 1'b0;
    logic [LEN_W-1:0]  capacity   = '0;

    logic              busy;
    logic              strobe;
    logic              status;
    logic [DATA_W-1:0] value_word;
    logic [WIDX_W-1:0] out_index;
    logic [LEN_W-1:0]  stored_length;
    logic              last;

    int fail_count;
    int outstanding;
    int results_checked;
    int get_hits;

    int items_sent   = 0;
    int puts_sent    = 0;
    int gets_sent    = 0;
    int idle_pct     = 0;
    int quiet_cycles = 0;
    int phase_pct [4] = '{0, 81, 0, 12};

    // what the cache should hold, kept only to keep gets legal
    bit [KEY_W-1:0]          held_key     [SLOTS];
    bit [LEN_W-1:0]          held_len     [SLOTS];
    bit [WORDS_PER_SLOT-1:0] filled_words [SLOTS];
    bit [KEY_W-1:0]          key_pool     [POOL_SIZE];

    always #4 clk = ~clk;

    direct_mapped_kv_cache u_dut (.*);

    kv_cache_checker u_checker (.*);

    always @(posedge clk)
    begin
        if ((start === 1'b1 && busy === 1'b0) || strobe === 1'b1)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("ERROR: no handshake for %0d cycles", quiet_cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic int slot_index(input logic [KEY_W-1:0] k);
        return int'((k * 64'd31) % SLOTS);
    endfunction

    function automatic logic [LEN_W-1:0] pick_length();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return LEN_W'(MAX_VALUE_BYTES);
        if (r < 15)
            return '0;
        if (r < 60)
            return LEN_W'($urandom_range(1, 40));
        return LEN_W'($urandom_range(41, 255));
    endfunction

    // Present one item after a random gap and hold it until the block takes it.
    task automatic issue(
        input logic              cmd,
        input logic [KEY_W-1:0]  k,
        input logic [LEN_W-1:0]  len,
        input logic [WIDX_W-1:0] widx,
        input logic [DATA_W-1:0] data,
        input logic              fin,
        input logic [LEN_W-1:0]  cap
    );
        int gap;
        int s;
        gap = 0;
        while (gap < 30 && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        command    <= cmd;
        key        <= k;
        length     <= len;
        word_index <= widx;
        data_word  <= data;
        final_word <= fin;
        capacity   <= cap;
        if (cmd == CMD_PUT && len <= MAX_VALUE_BYTES)
        begin
            s = slot_index(k);
            filled_words[s][widx] = 1'b1;
            if (fin)
            begin
                held_key[s] = k;
                held_len[s] = len;
            end
        end
        do @(posedge clk); while (busy !== 1'b0);
        items_sent++;
        if (cmd == CMD_PUT)
            puts_sent++;
        else
            gets_sent++;
    endtask

    task automatic lookup(input logic [KEY_W-1:0] k, input logic [LEN_W-1:0] cap);
        int                      s;
        int                      nw;
        bit [WORDS_PER_SLOT-1:0] need;
        logic [LEN_W-1:0]        c;
        s = slot_index(k);
        c = cap;
        // turn a hit on never-written value words into a too-small miss
        if (held_key[s] == k && held_len[s] != 0 && c >= held_len[s])
        begin
            nw   = (held_len[s] + 7) / 8;
            need = WORDS_PER_SLOT'((64'd1 << nw) - 64'd1);
            if ((filled_words[s] & need) != need)
                c = held_len[s] - 1'b1;
        end
        issue(CMD_GET, k, LEN_W'($urandom), WIDX_W'($urandom), {$urandom, $urandom},
              1'($urandom), c);
    endtask

    task automatic store_value(
        input logic [KEY_W-1:0] k,
        input logic [LEN_W-1:0] len,
        input put_shape_e       shape
    );
        int               order [$];
        int               nw;
        int               j;
        int               t;
        int               pick;
        logic [KEY_W-1:0] item_key;
        nw = (len + 7) / 8;
        if (len > MAX_VALUE_BYTES)
        begin
            repeat ($urandom_range(1, 3)) order.push_back($urandom_range(31));
        end
        else if (nw == 0)
        begin
            order.push_back($urandom_range(31));
        end
        else if (shape == PUT_PARTIAL)
        begin
            repeat ($urandom_range(1, nw)) order.push_back($urandom_range(nw - 1));
        end
        else
        begin
            for (j = 0; j < nw; j++)
                order.push_back(j);
            if (shape == PUT_SHUFFLED)
            begin
                for (j = nw - 1; j > 0; j--)
                begin
                    pick        = $urandom_range(j);
                    t           = order[j];
                    order[j]    = order[pick];
                    order[pick] = t;
                end
            end
        end
        for (j = 0; j < order.size(); j++)
        begin
            item_key = k;
            // now and then send a non-final word of the put under a random pool key instead
            if (shape == PUT_SHUFFLED && j + 1 < order.size() && $urandom_range(7) == 0)
                item_key = key_pool[$urandom_range(POOL_SIZE - 1)];
            issue(CMD_PUT, item_key, len, WIDX_W'(order[j]), {$urandom, $urandom},
                  j + 1 == order.size(), LEN_W'($urandom_range(256)));
        end
    endtask

    initial
    begin : stimulus
        logic [KEY_W-1:0] k_ones;
        logic [KEY_W-1:0] k_alias;
        int               i;
        int               roll;
        k_ones  = '1;
        k_alias = k_ones ^ (64'd1 << 40);
        // second half of the pool shares slots with the first half
        for (i = 0; i < POOL_SIZE / 2; i++)
        begin
            key_pool[i] = {$urandom, $urandom};
            key_pool[i + POOL_SIZE / 2] =
                key_pool[i] ^ (({$urandom, $urandom} & ~64'h3FF) | 64'h400);
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        idle_pct = 0;
        lookup('0, LEN_W'(MAX_VALUE_BYTES));
        issue(CMD_PUT, '0, 9'd8, '0, '1, 1'b1, '0);
        lookup('0, 9'd8);
        lookup('0, 9'd7);
        issue(CMD_PUT, k_ones, 9'd3, '0, {$urandom, $urandom}, 1'b1, LEN_W'(MAX_VALUE_BYTES));
        lookup(k_ones, LEN_W'(MAX_VALUE_BYTES));
        store_value(k_alias, 9'd16, PUT_FULL);
        lookup(k_ones, LEN_W'(MAX_VALUE_BYTES));
        lookup(k_alias, 9'd16);
        issue(CMD_PUT, k_alias, '1, 5'd31, {$urandom, $urandom}, 1'b1, '0);
        issue(CMD_PUT, k_alias, 9'd257, '0, {$urandom, $urandom}, 1'b1, '0);
        lookup(k_alias, LEN_W'(MAX_VALUE_BYTES));
        issue(CMD_PUT, 64'd5, '0, '0, {$urandom, $urandom}, 1'b1, '0);
        lookup(64'd5, LEN_W'(MAX_VALUE_BYTES));
        store_value(key_pool[0], 9'd9, PUT_FULL);
        lookup(key_pool[0], 9'd9);

        while (items_sent < ITEM_TARGET)
        begin
            idle_pct = phase_pct[(items_sent / 90) % 4];
            roll     = $urandom_range(99);
            if (roll < 40)
                store_value(key_pool[$urandom_range(POOL_SIZE - 1)], pick_length(), PUT_FULL);
            else if (roll < 75)
                lookup(key_pool[$urandom_range(POOL_SIZE - 1)],
                       roll < 66 ? LEN_W'(MAX_VALUE_BYTES) : LEN_W'($urandom_range(256)));
            else if (roll < 85)
                store_value(key_pool[$urandom_range(POOL_SIZE - 1)], pick_length(),
                            roll < 80 ? PUT_SHUFFLED : PUT_PARTIAL);
            else if (roll < 92)
                store_value(key_pool[$urandom_range(POOL_SIZE - 1)],
                            LEN_W'($urandom_range(257, 511)), PUT_FULL);
            else
                lookup({$urandom, $urandom}, LEN_W'($urandom_range(256)));
        end
        start <= 1'b0;

        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run: %0d items (%0d put words, %0d gets), %0d gets hit",
                 items_sent, puts_sent, gets_sent, get_hits);
        $display("Run: %0d results checked, %0d mismatches", results_checked, fail_count);
        if (fail_count == 0 && outstanding == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
